>>> rtl/sha1_pkg.sv
// sha1_pkg: shared types, constants and round functions for the sha-1 stream hash unit
// no dependencies
`timescale 1ns / 1ps

package sha1_pkg;

  // input item as one packed struct
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha1_in_t;

  // result item as one packed struct
  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } sha1_out_t;

  // command from front to back
  typedef enum logic [1:0] {
    CMD_BLOCK  = 2'd0,
    CMD_FINAL  = 2'd1,
    CMD_EXTRA  = 2'd2
  } sha1_cmd_e;

  // entry of the block queue: a full block and what to do with it
  typedef struct packed {
    sha1_cmd_e     cmd;
    logic [511:0]  block;
  } sha1_job_t;

  // front state machine
  typedef enum logic [1:0] {
    FS_COLLECT = 2'd0,
    FS_PAD     = 2'd1,
    FS_LEN     = 2'd2
  } sha1_front_e;

  // back state machine
  typedef enum logic [1:0] {
    BS_IDLE  = 2'd0,
    BS_ROUND = 2'd1,
    BS_ADD   = 2'd2,
    BS_EMIT  = 2'd3
  } sha1_back_e;

  localparam int unsigned QDepth = 2;
  localparam int unsigned NumRounds = 80;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  // round constant by round number
  function automatic logic [31:0] round_k(input logic [6:0] t);
    if (t < 7'd20)      round_k = 32'h5a827999;
    else if (t < 7'd40) round_k = 32'h6ed9eba1;
    else if (t < 7'd60) round_k = 32'h8f1bbcdc;
    else                round_k = 32'hca62c1d6;
  endfunction

  // boolean function by round number
  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (t < 7'd20)      round_f = (b & c) ^ (~b & d);
    else if (t < 7'd40) round_f = b ^ c ^ d;
    else if (t < 7'd60) round_f = (b & c) ^ (b & d) ^ (c & d);
    else                round_f = b ^ c ^ d;
  endfunction

endpackage

>>> rtl/sha1_front.sv
// sha1_front: packs message bytes into blocks and builds the padding blocks
// depends on sha1_pkg
`timescale 1ns / 1ps

module sha1_front import sha1_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sha1_in_t  item_i,
  input  logic      push_i,
  output logic      full_o,
  output sha1_job_t job_o,
  output logic      job_valid_o,
  input  logic      job_ready_i
);

  sha1_front_e state_q, state_d;
  logic [511:0] blk_q, blk_d;
  logic [60:0]  cnt_q, cnt_d;
  logic [63:0]  bits;
  logic [5:0]   pos;
  logic [5:0]   ppos;
  logic [60:0]  cnt_inc;
  logic [511:0] blk_byte;
  logic [511:0] blk_pad;
  logic         accept;

  assign accept  = push_i && !full_o;
  assign pos     = cnt_q[5:0];
  assign cnt_inc = cnt_q + 61'd1;
  assign bits    = {cnt_q, 3'b000};

  // place the byte at its big-endian slot; the first byte of a block clears the rest of it
  always_comb begin
    blk_byte = blk_q;
    if (pos == 6'd0) blk_byte = '0;
    blk_byte[511 - 8 * pos -: 8] = item_i.data_byte;
  end

  // block after the present byte, padded with 0x80 and zeros
  always_comb begin
    blk_pad = (item_i.byte_present) ? blk_byte : blk_q;
    ppos = item_i.byte_present ? cnt_inc[5:0] : pos;
    if (ppos == 6'd0) blk_pad = '0;
    blk_pad[511 - 8 * ppos -: 8] = 8'h80;
    for (int i = 0; i < 64; i++) begin
      if (i > ppos) blk_pad[511 - 8 * i -: 8] = 8'h00;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FS_COLLECT: begin
        if (accept && item_i.end_of_message) state_d = FS_PAD;
      end
      FS_PAD: begin
        if (job_ready_i) state_d = (pos >= 6'd56) ? FS_LEN : FS_COLLECT;
      end
      FS_LEN: begin
        if (job_ready_i) state_d = FS_COLLECT;
      end
      default: state_d = FS_COLLECT;
    endcase
  end

  // outputs and data path
  always_comb begin
    blk_d       = blk_q;
    cnt_d       = cnt_q;
    job_valid_o = 1'b0;
    job_o.cmd   = CMD_BLOCK;
    job_o.block = blk_byte;
    full_o      = 1'b1;
    case (state_q)
      FS_COLLECT: begin
        full_o = !job_ready_i;
        if (accept) begin
          if (item_i.byte_present) begin
            cnt_d = cnt_inc;
            blk_d = blk_byte;
            job_valid_o = (pos == 6'd63);
          end
          if (item_i.end_of_message) blk_d = blk_pad;
        end
      end
      FS_PAD: begin
        job_valid_o = 1'b1;
        job_o.block = blk_q;
        if (pos < 6'd56) begin
          job_o.cmd = CMD_FINAL;
          job_o.block[63:0] = bits;
        end else begin
          job_o.cmd = CMD_EXTRA;
        end
        if (job_ready_i && pos < 6'd56) cnt_d = '0;
      end
      FS_LEN: begin
        job_valid_o = 1'b1;
        job_o.cmd   = CMD_FINAL;
        job_o.block = {448'd0, bits};
        if (job_ready_i) cnt_d = '0;
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_COLLECT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

`ifndef NO_ASSERTIONS
  // a padding job goes out only from a padding state
  a_final_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && job_o.cmd == CMD_FINAL |-> state_q != FS_COLLECT)
    else $error("final job outside padding");
  // counter clears after the length block is handed on
  a_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && job_ready_i && job_o.cmd == CMD_FINAL |=> cnt_q == '0)
    else $error("count not cleared");
  // no item taken while padding
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != FS_COLLECT |-> full_o)
    else $error("item taken while padding");
`endif

endmodule

>>> rtl/sha1_fifo.sv
// sha1_fifo: short queue of block jobs between front and back
// depends on sha1_pkg
`timescale 1ns / 1ps

module sha1_fifo import sha1_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sha1_job_t wr_data_i,
  input  logic      wr_valid_i,
  output logic      wr_ready_o,
  output sha1_job_t rd_data_o,
  output logic      rd_valid_o,
  input  logic      rd_ready_i
);

  sha1_job_t    mem_q [QDepth];
  logic [0:0]   wp_q, rp_q;
  logic [1:0]   cnt_q;
  logic         wr, rd;

  assign wr_ready_o = (cnt_q != 2'(QDepth));
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

`ifndef NO_ASSERTIONS
  // fill count stays within depth
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("queue overflow");
  // count follows transfers
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && !rd |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
  a_cnt_dn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd && !wr |=> cnt_q == $past(cnt_q) - 2'd1) else $error("count slip");
`endif

endmodule

>>> rtl/sha1_core.sv
// sha1_core: 80-round compression, one round per cycle, and digest output
// depends on sha1_pkg
`timescale 1ns / 1ps

module sha1_core import sha1_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sha1_job_t job_i,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  output sha1_out_t res_o,
  output logic      res_valid_o,
  input  logic      res_ready_i
);

  sha1_back_e   state_q, state_d;
  logic [31:0]  h_q [5];
  logic [31:0]  v_q [5];
  logic [31:0]  w_q [16];
  logic [6:0]   t_q, t_d;
  logic [2:0]   k_q, k_d;
  logic         fin_q;
  logic [31:0]  w_new, w_cur, tmp;
  logic         load, step, add, emit_step;

  // schedule word and round sum
  assign w_new = {w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]};
  assign w_cur = (t_q < 7'd16) ? w_q[0] : {w_new[30:0], w_new[31]};
  assign tmp = {v_q[0][26:0], v_q[0][31:27]} + round_f(t_q, v_q[1], v_q[2], v_q[3])
             + v_q[4] + round_k(t_q) + w_cur;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_IDLE:  if (job_valid_i) state_d = BS_ROUND;
      BS_ROUND: if (t_q == 7'(NumRounds - 1)) state_d = BS_ADD;
      BS_ADD:   state_d = fin_q ? BS_EMIT : BS_IDLE;
      BS_EMIT:  if (res_ready_i && k_q == 3'd4) state_d = BS_IDLE;
      default:  state_d = BS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_ready_o = 1'b0;
    res_valid_o = 1'b0;
    t_d = t_q;
    k_d = k_q;
    case (state_q)
      BS_IDLE:  begin job_ready_o = 1'b1; t_d = '0; k_d = '0; end
      BS_ROUND: t_d = t_q + 7'd1;
      BS_EMIT:  begin
        res_valid_o = 1'b1;
        if (res_ready_i) k_d = (k_q == 3'd4) ? 3'd0 : k_q + 3'd1;
      end
      default: ;
    endcase
  end

  assign load = (state_q == BS_IDLE) && job_valid_i;
  assign step = (state_q == BS_ROUND);
  assign add  = (state_q == BS_ADD);
  assign emit_step = (state_q == BS_EMIT) && res_ready_i;
  assign res_o.digest_word = h_q[k_q];
  assign res_o.last_word   = (k_q == 3'd4);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      t_q <= '0;
      k_q <= '0;
      fin_q <= 1'b0;
      h_q[0] <= IV0; h_q[1] <= IV1; h_q[2] <= IV2; h_q[3] <= IV3; h_q[4] <= IV4;
    end else begin
      state_q <= state_d;
      t_q <= t_d;
      k_q <= k_d;
      if (load) fin_q <= (job_i.cmd == CMD_FINAL);
      if (add) begin
        for (int i = 0; i < 5; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (emit_step && k_q == 3'd4) begin
        h_q[0] <= IV0; h_q[1] <= IV1; h_q[2] <= IV2; h_q[3] <= IV3; h_q[4] <= IV4;
      end
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < 16; i++) w_q[i] <= job_i.block[511 - 32 * i -: 32];
      for (int i = 0; i < 5; i++) v_q[i] <= h_q[i];
    end else if (step) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= w_cur;
      v_q[0] <= tmp;
      v_q[1] <= v_q[0];
      v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3];
    end
  end

`ifndef NO_ASSERTIONS
  // round counter only runs in round state
  a_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != BS_ROUND |=> state_q != BS_ROUND || t_q == '0)
    else $error("round count not reset");
  // emit only after a final block
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == BS_EMIT) |-> fin_q) else $error("emit without final");
  // chain reset after fifth word
  a_iv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_step && k_q == 3'd4 |=> h_q[0] == IV0) else $error("chain not reset");
`endif

endmodule

>>> rtl/sha1_stream_hash_unit.sv
// sha1_stream_hash_unit: top level of the sha-1 byte stream hash
// depends on sha1_pkg, sha1_front, sha1_fifo, sha1_core
`timescale 1ns / 1ps

// SHA-1 over a byte stream. The front packs one byte per cycle, while it is not
// full, into 512-bit blocks and builds padding; full blocks queue for the back,
// which runs one round per cycle (a load step, 80 rounds and an add step per
// block). Bytes are taken while the front collects and the queue has room; over
// a full message the byte rate is set by the round loop. After the end
// item the five digest words, H0 first, follow one per cycle as they are popped.
module sha1_stream_hash_unit import sha1_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sha1_in_t  in_i,
  input  logic      push,
  output logic      full,
  output sha1_out_t out_o,
  output logic      empty,
  input  logic      pop
);

  sha1_job_t f_job, c_job;
  logic      f_valid, f_ready, c_valid, c_ready, r_valid;

  sha1_front u_front (
    .clk_i, .rst_ni, .item_i(in_i), .push_i(push), .full_o(full),
    .job_o(f_job), .job_valid_o(f_valid), .job_ready_i(f_ready)
  );

  sha1_fifo u_fifo (
    .clk_i, .rst_ni, .wr_data_i(f_job), .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .rd_data_o(c_job), .rd_valid_o(c_valid), .rd_ready_i(c_ready)
  );

  sha1_core u_core (
    .clk_i, .rst_ni, .job_i(c_job), .job_valid_i(c_valid), .job_ready_o(c_ready),
    .res_o(out_o), .res_valid_o(r_valid), .res_ready_i(pop)
  );

  assign empty = !r_valid;

endmodule
